### rtl/snma_pkg.sv
// Shared types and constants of the star neighbourhood majority automaton.
package snma_pkg;

   localparam int ROW_BITS       = 64;
   localparam int INDEX_BITS     = 10;
   localparam int RADIUS_BITS    = 4;
   localparam int CSR_DATA_BITS  = 7;
   localparam int CSR_INDEX_BITS = 2;

   localparam int MAX_WIDTH_DEFAULT  = 64;
   localparam int MAX_RADIUS_DEFAULT = 4;
   localparam int MAX_HEIGHT_DEFAULT = 1024;

   localparam logic [6:0] ROW_WIDTH_RESET  = 7'd64;
   localparam logic [2:0] RADIUS_RESET     = 3'd1;
   localparam logic       CAVES_MODE_RESET = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROW_WIDTH  = 2'd0,
      CSR_RADIUS     = 2'd1,
      CSR_CAVES_MODE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] row_cells;
      logic                last_row;
   } req_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]   next_row;
      logic [INDEX_BITS-1:0] row_index;
      logic                  row_changed;
      logic                  last_result;
      logic                  frame_stable;
   } rsp_type;

endpackage

### rtl/star_neighbourhood_majority_automaton.sv
// Top level of the star neighbourhood majority automaton, one grid row per transfer.
//
// The request channel carries one row of the current generation per transfer, top
// row first, with last_row set on the final row of the grid. The response channel
// carries rows of the next generation in order, each with its row number, a changed
// flag, and on the final row of the frame the stable flag for the whole generation.
// Register writes on the csr port set the row width, the radius and the rule; the user
// must make them only while the block is idle, which the block itself does not enforce.
// Throughput is one row per cycle while the receiver does not stall and no flush runs:
// a row window of 2*MAX_RADIUS+1 registers feeds the neighbour counts, and the result
// register takes a new row in every cycle unless the receiver stalls. Row y is computed
// once row y+radius is in the window. After the last row the block flushes the remaining
// rows by shifting radius empty rows into the window, one per cycle while the receiver
// does not stall, and the request channel is stalled until the flush is done.
// While the receiver stalls, the result register holds its row and the window holds
// one more; the request channel stalls only when both are full or while the block flushes.
// Reset is synchronous; it empties the window and the output register and restores
// row width 64, radius 1 and the caves rule.
module star_neighbourhood_majority_automaton
   import snma_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_RADIUS = MAX_RADIUS_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
   localparam int RS_W      = $clog2(MAX_HEIGHT);
   localparam int CNT_W     = $clog2(8 * MAX_RADIUS + 1);

   logic [6:0]             row_width_ff, row_width_in;
   logic [2:0]             radius_ff, radius_in;
   logic                   caves_ff, caves_in;

   logic [MAX_WIDTH-1:0]   win_ff [WIN_DEPTH];
   logic [MAX_WIDTH-1:0]   win_in [WIN_DEPTH];
   logic [WIN_DEPTH-1:0]   win_vld_ff, win_vld_in;
   logic                   emit_ff, emit_in;
   logic                   final_ff, final_in;
   logic [INDEX_BITS-1:0]  idx_ff, idx_in;
   logic                   flush_ff, flush_in;
   logic [RADIUS_BITS-1:0] flush_cnt_ff, flush_cnt_in;
   logic [RS_W-1:0]        rows_seen_ff, rows_seen_in;
   logic                   any_change_ff, any_change_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [6:0]             eff_w;
   logic [RADIUS_BITS-1:0] eff_r;
   logic [MAX_WIDTH-1:0]   mask;
   logic [MAX_WIDTH-1:0]   tap_m [WIN_DEPTH];
   logic [MAX_WIDTH-1:0]   center_row;
   logic                   prev_vld;
   logic [MAX_WIDTH-1:0]   up_v [1:MAX_RADIUS];
   logic [MAX_WIDTH-1:0]   dn_v [1:MAX_RADIUS];
   logic [MAX_WIDTH-1:0]   up_lo [1:MAX_RADIUS];
   logic [MAX_WIDTH-1:0]   up_hi [1:MAX_RADIUS];
   logic [MAX_WIDTH-1:0]   dn_lo [1:MAX_RADIUS];
   logic [MAX_WIDTH-1:0]   dn_hi [1:MAX_RADIUS];
   logic [MAX_WIDTH-1:0]   ctr_lo [1:MAX_RADIUS];
   logic [MAX_WIDTH-1:0]   ctr_hi [1:MAX_RADIUS];
   logic [CNT_W-1:0]       cnt_v [MAX_WIDTH];
   logic [CNT_W-1:0]       thr_keep;
   logic [MAX_WIDTH-1:0]   fresh;
   logic                   changed;

   logic                   load_out;
   logic                   win_free;
   logic                   req_acc;
   logic                   flush_step;
   logic                   is_last;
   logic                   frame_start;

   // Effective width and radius, clamped to the supported range.
   always_comb begin
      if (row_width_ff == 7'd0) begin
         eff_w = 7'd1;
      end else if (row_width_ff > 7'(MAX_WIDTH)) begin
         eff_w = 7'(MAX_WIDTH);
      end else begin
         eff_w = row_width_ff;
      end
      if (radius_ff == 3'd0) begin
         eff_r = RADIUS_BITS'(1);
      end else if ({1'b0, radius_ff} > RADIUS_BITS'(MAX_RADIUS)) begin
         eff_r = RADIUS_BITS'(MAX_RADIUS);
      end else begin
         eff_r = {1'b0, radius_ff};
      end
      for (int x = 0; x < MAX_WIDTH; x++) begin
         mask[x] = 7'(x) < eff_w;
      end
      for (int k = 0; k < WIN_DEPTH; k++) begin
         tap_m[k] = win_ff[k] & mask & {MAX_WIDTH{win_vld_ff[k]}};
      end
   end

   // The row being emitted sits at tap radius; older rows above it, newer rows below.
   always_comb begin
      center_row = '0;
      prev_vld   = 1'b0;
      for (int d = 1; d <= MAX_RADIUS; d++) begin
         up_v[d] = '0;
         dn_v[d] = '0;
      end
      for (int rr = 1; rr <= MAX_RADIUS; rr++) begin
         if (eff_r == RADIUS_BITS'(rr)) begin
            center_row = tap_m[rr];
            prev_vld   = win_vld_ff[rr-1];
            for (int d = 1; d <= rr; d++) begin
               up_v[d] = tap_m[rr+d];
               dn_v[d] = tap_m[rr-d];
            end
         end
      end
   end

   always_comb begin
      for (int d = 1; d <= MAX_RADIUS; d++) begin
         up_lo[d] = up_v[d] << d;
         up_hi[d] = up_v[d] >> d;
         dn_lo[d] = dn_v[d] << d;
         dn_hi[d] = dn_v[d] >> d;
         if (RADIUS_BITS'(d) <= eff_r) begin
            ctr_lo[d] = center_row << d;
            ctr_hi[d] = center_row >> d;
         end else begin
            ctr_lo[d] = '0;
            ctr_hi[d] = '0;
         end
      end
   end

   always_comb begin
      thr_keep = CNT_W'({eff_r, 2'b00});
      for (int x = 0; x < MAX_WIDTH; x++) begin
         cnt_v[x] = '0;
         for (int d = 1; d <= MAX_RADIUS; d++) begin
            cnt_v[x] = cnt_v[x] + CNT_W'(up_v[d][x]) + CNT_W'(up_lo[d][x])
                     + CNT_W'(up_hi[d][x]) + CNT_W'(dn_v[d][x]) + CNT_W'(dn_lo[d][x])
                     + CNT_W'(dn_hi[d][x]) + CNT_W'(ctr_lo[d][x]) + CNT_W'(ctr_hi[d][x]);
         end
         if (cnt_v[x] > thr_keep) begin
            fresh[x] = mask[x];
         end else if (caves_ff && cnt_v[x] == thr_keep) begin
            fresh[x] = center_row[x];
         end else begin
            fresh[x] = 1'b0;
         end
      end
      changed = fresh != center_row;
   end

   // Handshake and control.
   assign load_out    = emit_ff && (!rsp_valid_ff || !rsp_stall);
   assign win_free    = !emit_ff || load_out;
   assign req_stall   = flush_ff || !win_free;
   assign req_acc     = req_valid && !req_stall;
   assign flush_step  = flush_ff && win_free;
   assign frame_start = rows_seen_ff == '0;
   assign is_last     = req_data.last_row || rows_seen_ff == RS_W'(MAX_HEIGHT - 1);

   always_comb begin
      row_width_in  = row_width_ff;
      radius_in     = radius_ff;
      caves_in      = caves_ff;
      win_in        = win_ff;
      win_vld_in    = win_vld_ff;
      emit_in       = emit_ff;
      final_in      = final_ff;
      idx_in        = idx_ff;
      flush_in      = flush_ff;
      flush_cnt_in  = flush_cnt_ff;
      rows_seen_in  = rows_seen_ff;
      any_change_in = any_change_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_ROW_WIDTH:  row_width_in = csr_wdata;
            CSR_RADIUS:     radius_in    = csr_wdata[2:0];
            CSR_CAVES_MODE: caves_in     = csr_wdata[0];
            default:        ;
         endcase
      end

      if (req_acc) begin
         win_in[0]     = MAX_WIDTH'(req_data.row_cells);
         win_vld_in[0] = 1'b1;
         for (int k = 1; k < WIN_DEPTH; k++) begin
            win_in[k]     = win_ff[k-1];
            win_vld_in[k] = win_vld_ff[k-1] && !frame_start;
         end
         emit_in  = rows_seen_ff >= RS_W'(eff_r);
         final_in = 1'b0;
         idx_in   = INDEX_BITS'(rows_seen_ff) - INDEX_BITS'(eff_r);
         if (is_last) begin
            flush_in     = 1'b1;
            flush_cnt_in = eff_r;
            rows_seen_in = '0;
         end else begin
            rows_seen_in = rows_seen_ff + RS_W'(1);
         end
      end else if (flush_step) begin
         win_in[0]     = '0;
         win_vld_in[0] = 1'b0;
         for (int k = 1; k < WIN_DEPTH; k++) begin
            win_in[k]     = win_ff[k-1];
            win_vld_in[k] = win_vld_ff[k-1];
         end
         emit_in      = prev_vld;
         final_in     = flush_cnt_ff == RADIUS_BITS'(1);
         idx_in       = idx_ff + INDEX_BITS'(1);
         flush_cnt_in = flush_cnt_ff - RADIUS_BITS'(1);
         if (flush_cnt_ff == RADIUS_BITS'(1)) begin
            flush_in = 1'b0;
         end
      end else if (load_out) begin
         emit_in = 1'b0;
      end

      if (load_out) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.next_row     = ROW_BITS'(fresh);
         rsp_data_in.row_index    = idx_ff;
         rsp_data_in.row_changed  = changed;
         rsp_data_in.last_result  = final_ff;
         rsp_data_in.frame_stable = final_ff && !any_change_ff && !changed;
         if (final_ff) begin
            any_change_in = 1'b0;
         end else if (changed) begin
            any_change_in = 1'b1;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= ROW_WIDTH_RESET;
         radius_ff     <= RADIUS_RESET;
         caves_ff      <= CAVES_MODE_RESET;
         win_vld_ff    <= '0;
         emit_ff       <= 1'b0;
         final_ff      <= 1'b0;
         flush_ff      <= 1'b0;
         flush_cnt_ff  <= '0;
         rows_seen_ff  <= '0;
         any_change_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         row_width_ff  <= row_width_in;
         radius_ff     <= radius_in;
         caves_ff      <= caves_in;
         win_vld_ff    <= win_vld_in;
         emit_ff       <= emit_in;
         final_ff      <= final_in;
         flush_ff      <= flush_in;
         flush_cnt_ff  <= flush_cnt_in;
         rows_seen_ff  <= rows_seen_in;
         any_change_ff <= any_change_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### tb/sv/star_neighbourhood_majority_automaton_test.sv
// Self-checking testbench of the star neighbourhood majority automaton with a row predictor.
`timescale 1ns / 100ps

module star_neighbourhood_majority_automaton_test
   import snma_pkg::*;
();

   localparam int STORE_DEPTH = 2 * MAX_RADIUS_DEFAULT + 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_type                   rsp_data;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   logic [ROW_BITS-1:0] grid_rows [STORE_DEPTH];
   int unsigned         frame_rows;
   bit                  frame_dirty;
   logic [6:0]          cfg_width;
   logic [2:0]          cfg_radius;
   logic                cfg_caves;

   rsp_type expected_rows [$];
   int      req_transfers;
   int      rsp_transfers;
   int      error_count;
   bit      quiet;

   star_neighbourhood_majority_automaton dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int used_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_WIDTH_DEFAULT) return MAX_WIDTH_DEFAULT;
      return int'(cfg_width);
   endfunction

   function automatic int used_radius();
      if (cfg_radius == 0) return 1;
      if (cfg_radius > MAX_RADIUS_DEFAULT) return MAX_RADIUS_DEFAULT;
      return int'(cfg_radius);
   endfunction

   function automatic logic [ROW_BITS-1:0] grid_row(int y, int last);
      if (y < 0 || y > last) return '0;
      return grid_rows[y % STORE_DEPTH];
   endfunction

   function automatic int cell_of(logic [ROW_BITS-1:0] row, int col, int w);
      if (col < 0 || col >= w) return 0;
      return int'(row[col]);
   endfunction

   function automatic void add_next_row(int y, int last, bit final_row);
      int                  w;
      int                  r;
      int                  count;
      logic [ROW_BITS-1:0] mask;
      logic [ROW_BITS-1:0] old;
      logic [ROW_BITS-1:0] fresh;
      logic [ROW_BITS-1:0] up;
      logic [ROW_BITS-1:0] dn;
      rsp_type             item;
      w = used_width();
      r = used_radius();
      mask = (w >= ROW_BITS) ? {ROW_BITS{1'b1}} : ((64'd1 << w) - 64'd1);
      old = grid_row(y, last) & mask;
      fresh = '0;
      for (int col = 0; col < w; col++) begin
         count = 0;
         for (int d = 1; d <= r; d++) begin
            up = grid_row(y - d, last);
            dn = grid_row(y + d, last);
            count += cell_of(up, col, w) + cell_of(up, col - d, w) + cell_of(up, col + d, w);
            count += cell_of(dn, col, w) + cell_of(dn, col - d, w) + cell_of(dn, col + d, w);
            count += cell_of(old, col - d, w) + cell_of(old, col + d, w);
         end
         if (count >= 4 * r + 1) fresh[col] = 1'b1;
         else if (cfg_caves && count == 4 * r) fresh[col] = old[col];
         else fresh[col] = 1'b0;
      end
      if (fresh != old) frame_dirty = 1'b1;
      item.next_row     = fresh;
      item.row_index    = y[INDEX_BITS-1:0];
      item.row_changed  = (fresh != old);
      item.last_result  = final_row;
      item.frame_stable = final_row && !frame_dirty;
      expected_rows = {expected_rows, item};
   endfunction

   function automatic void predict_generation(req_type row_in);
      int n;
      int r;
      bit last;
      n = int'(frame_rows);
      r = used_radius();
      last = row_in.last_row || (frame_rows >= MAX_HEIGHT_DEFAULT - 1);
      grid_rows[n % STORE_DEPTH] = row_in.row_cells;
      if (!last) begin
         if (n >= r) add_next_row(n - r, n + r, 1'b0);
         frame_rows++;
      end else begin
         for (int y = (n >= r) ? n - r : 0; y <= n; y++) add_next_row(y, n, y == n);
         frame_rows = 0;
         frame_dirty = 1'b0;
      end
   endfunction

   task automatic report_mismatch(string what, logic [ROW_BITS-1:0] exp_value,
                                  logic [ROW_BITS-1:0] got_value);
      $display("mismatch in %s: expected %h, got %h", what, exp_value, got_value);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_generation(req_data);
            req_transfers++;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_transfers++;
            if (expected_rows.size() == 0) begin
               report_mismatch("unexpected transfer, row_index", '0,
                               ROW_BITS'(rsp_data.row_index));
            end else begin
               want = expected_rows.pop_front();
               if (rsp_data.next_row !== want.next_row)
                  report_mismatch($sformatf("next_row of row %0d", want.row_index),
                                  want.next_row, rsp_data.next_row);
               if (rsp_data.row_index !== want.row_index)
                  report_mismatch("row_index", ROW_BITS'(want.row_index),
                                  ROW_BITS'(rsp_data.row_index));
               if (rsp_data.row_changed !== want.row_changed)
                  report_mismatch($sformatf("row_changed of row %0d", want.row_index),
                                  ROW_BITS'(want.row_changed),
                                  ROW_BITS'(rsp_data.row_changed));
               if (rsp_data.last_result !== want.last_result)
                  report_mismatch($sformatf("last_result of row %0d", want.row_index),
                                  ROW_BITS'(want.last_result),
                                  ROW_BITS'(rsp_data.last_result));
               if (rsp_data.frame_stable !== want.frame_stable)
                  report_mismatch($sformatf("frame_stable of row %0d", want.row_index),
                                  ROW_BITS'(want.frame_stable),
                                  ROW_BITS'(rsp_data.frame_stable));
            end
         end
      end
   end

   initial begin
      int hold;
      int seen;
      rsp_stall = 1'b0;
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 5);
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         seen = rsp_transfers;
         do @(negedge clock); while (rsp_transfers == seen);
      end
   end

   task automatic send_row(logic [ROW_BITS-1:0] cells, logic last);
      int gap;
      int seen;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.row_cells = cells;
      req_data.last_row = last;
      seen = req_transfers;
      do @(negedge clock); while (req_transfers == seen);
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (expected_rows.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         CSR_ROW_WIDTH:  cfg_width = value;
         CSR_RADIUS:     cfg_radius = value[2:0];
         CSR_CAVES_MODE: cfg_caves = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure(logic [6:0] width, logic [2:0] radius, logic caves);
      settle();
      write_reg(CSR_ROW_WIDTH, width);
      write_reg(CSR_RADIUS, {4'($urandom), radius});
      write_reg(CSR_CAVES_MODE, {6'($urandom), caves});
   endtask

   function automatic logic [ROW_BITS-1:0] random_row();
      logic [ROW_BITS-1:0] a;
      logic [ROW_BITS-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0, 1:    return a | b;
         2, 3:    return a & b;
         4:       return a | b | {$urandom, $urandom};
         5:       return ($urandom_range(0, 1) != 0) ? {ROW_BITS{1'b1}} : '0;
         default: return a;
      endcase
   endfunction

   task automatic send_frame(int rows);
      for (int i = 0; i < rows; i++) send_row(random_row(), i == rows - 1);
   endtask

   task automatic test_default_rule();
      send_row({ROW_BITS{1'b1}}, 1'b1);
      send_row({ROW_BITS{1'b1}}, 1'b0);
      send_row('0, 1'b0);
      send_row(64'h5555_5555_5555_5555, 1'b0);
      send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_row({ROW_BITS{1'b1}}, 1'b1);
   endtask

   task automatic test_wide_majority();
      configure(7'd64, 3'd4, 1'b0);
      send_row({ROW_BITS{1'b1}}, 1'b0);
      send_row(64'h8000_0000_0000_0001, 1'b0);
      send_row({ROW_BITS{1'b1}}, 1'b0);
      send_row(random_row(), 1'b0);
      send_row('0, 1'b0);
      send_row({ROW_BITS{1'b1}}, 1'b1);
   endtask

   task automatic test_register_limits();
      configure(7'd0, 3'd0, 1'b1);
      write_reg(CSR_UNUSED, 7'($urandom));
      send_row({ROW_BITS{1'b1}}, 1'b0);
      send_row({ROW_BITS{1'b1}}, 1'b1);
      configure(7'd127, 3'd7, 1'b0);
      send_row({ROW_BITS{1'b1}}, 1'b0);
      send_row({ROW_BITS{1'b1}}, 1'b0);
      send_row('0, 1'b1);
      configure(7'd1, 3'd1, 1'b1);
      send_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
      send_row(64'h1, 1'b0);
      send_row({ROW_BITS{1'b1}}, 1'b1);
   endtask

   task automatic test_random_frames();
      int sent;
      int phase;
      int rows;
      sent = 0;
      phase = 0;
      while (sent < 110) begin
         case (phase)
            0:       configure(7'd64, 3'd4, 1'b0);
            1:       configure(7'd1, 3'd1, 1'b1);
            2:       configure(7'd64, 3'd1, 1'b0);
            default: configure(($urandom_range(0, 2) != 0) ? 7'($urandom_range(1, 64))
                                                             : 7'($urandom_range(0, 127)),
                               3'($urandom_range(0, 7)), 1'($urandom));
         endcase
         quiet = (phase % 4 == 3);
         for (int f = 0; f < 4; f++) begin
            rows = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
            send_frame(rows);
            sent += rows;
         end
         quiet = 1'b0;
         phase++;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_ROW_WIDTH;
      csr_wdata = '0;
      quiet = 1'b0;
      req_transfers = 0;
      rsp_transfers = 0;
      error_count = 0;
      for (int i = 0; i < STORE_DEPTH; i++) grid_rows[i] = '0;
      frame_rows = 0;
      frame_dirty = 1'b0;
      cfg_width = ROW_WIDTH_RESET;
      cfg_radius = RADIUS_RESET;
      cfg_caves = CAVES_MODE_RESET;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_default_rule();
      test_wide_majority();
      test_register_limits();
      test_random_frames();

      settle();
      repeat (20) @(negedge clock);
      if (expected_rows.size() != 0)
         report_mismatch("rows still expected", '0, ROW_BITS'(expected_rows.size()));
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### star_neighbourhood_majority_automaton.f
rtl/snma_pkg.sv
rtl/star_neighbourhood_majority_automaton.sv
tb/sv/star_neighbourhood_majority_automaton_test.sv
